>>> sv/vcf_pkg.sv
// Package: shared constants and types of the voxel clearance filter.
package vcf_pkg;
   localparam int GRID_X     = 64;
   localparam int GRID_Y     = 32;
   localparam int GRID_Z     = 64;
   localparam int MAX_RADIUS = 7;
   localparam int MAX_HEIGHT = 31;

   localparam int XW      = $clog2(GRID_X);
   localparam int YW      = $clog2(GRID_Y);
   localparam int ZW      = $clog2(GRID_Z);
   localparam int ROWS    = GRID_Y * GRID_Z;
   localparam int AW      = $clog2(ROWS);
   localparam int SPAN    = 2 * MAX_RADIUS + 1;
   localparam int CNT_W   = $clog2(GRID_X + 1);
   localparam int HIT_W   = 13;
   localparam int LIMIT_W = 17;
   localparam int DZ_W    = 4;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] REG_CLIMB_MIN  = 2'd0;
   localparam logic [1:0] REG_HEIGHT_MAX = 2'd1;
   localparam logic [1:0] REG_RADIUS     = 2'd2;
   localparam logic [1:0] REG_DISK_LIMIT = 2'd3;

   typedef struct packed {
      logic [XW-1:0]   px;
      logic [SPAN-1:0] dx_mask;
   } lane_ctl_type;
endpackage

>>> sv/vcf_req_if.sv
// Interface: request channel carrying write and query items.
interface vcf_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [5:0] pos_x;
   logic [4:0] pos_y;
   logic [5:0] pos_z;
   logic       occupied;
   logic       walkable_in;
   modport source (output valid, op, pos_x, pos_y, pos_z, occupied, walkable_in,
                   input ready);
   modport sink   (input valid, op, pos_x, pos_y, pos_z, occupied, walkable_in,
                   output ready);
endinterface

>>> sv/vcf_rsp_if.sv
// Interface: response channel carrying query results.
interface vcf_rsp_if;
   logic        valid;
   logic        ready;
   logic        walkable_out;
   logic [12:0] hit_count;
   modport source (output valid, walkable_out, hit_count, input ready);
   modport sink   (input valid, walkable_out, hit_count, output ready);
endinterface

>>> sv/voxel_clearance_filter.sv
// Top level: voxel occupancy store and walkable clearance filter.
//
//  channel | dir | transfer moves
//  req_ch  | in  | write cell (op 0) or clearance query (op 1)
//  rsp_ch  | out | walkable_out, hit_count, one per query
//  csr_*   | in  | register write, no read-back
//
// Sequence: a write reads the row, then writes it back. A query scans one
// grid row (all x for one y,z) per cycle over (height-climb+1)*(2r+1) rows
// between its accept step and the pipeline drain and result load; queries
// that skip the scan go straight from accept to result load. The single RAM
// read port sets this scan rate.
// Reset: a clearing pass writes zeros over all 2048 rows, with req_ch.ready
// low. A pending result waits in the output register while the next item is
// accepted; a new result waits until that register is free.
module voxel_clearance_filter import vcf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   vcf_req_if.sink            req_ch,
   vcf_rsp_if.source          rsp_ch,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [LIMIT_W-1:0] csr_wdata
);
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_WMOD  = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   // Configuration registers
   logic [4:0]                climb_ff, height_ff;
   logic [2:0]                radius_ff;
   logic signed [LIMIT_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         climb_ff  <= 5'd1;
         height_ff <= 5'd8;
         radius_ff <= 3'd2;
         limit_ff  <= LIMIT_W'(768);
      end else if (csr_we) begin
         case (csr_index)
            REG_CLIMB_MIN:  climb_ff  <= csr_wdata[4:0];
            REG_HEIGHT_MAX: height_ff <= csr_wdata[4:0];
            REG_RADIUS:     radius_ff <= csr_wdata[2:0];
            REG_DISK_LIMIT: limit_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Control and item registers
   logic [2:0]             state_ff, state_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [XW-1:0]          px_ff, px_in;
   logic [YW-1:0]          py_ff, py_in;
   logic [ZW-1:0]          pz_ff, pz_in;
   logic                   occ_ff, occ_in;
   logic                   walk_ff, walk_in;
   logic [AW-1:0]          waddr_ff, waddr_in;
   logic [4:0]             dy_ff, dy_in;
   logic signed [DZ_W-1:0] dz_ff, dz_in;
   logic [HIT_W-1:0]       acc_ff, acc_in;
   // Scan pipeline
   logic                   p1_v_ff, p1_in_ff;
   lane_ctl_type           p1_ctl_ff;
   logic                   p2_v_ff;
   logic [CNT_W-1:0]       p2_cnt_ff;
   // Output register
   logic                   rsp_v_ff, rsp_v_in;
   logic                   rsp_walk_ff, rsp_walk_in;
   logic [HIT_W-1:0]       rsp_hits_ff, rsp_hits_in;

   logic req_xfer;
   logic ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [GRID_X-1:0] ram_wdata, ram_rdata;
   logic [CNT_W-1:0]  lane_cnt;

   // Row address of the cell being scanned
   logic [YW:0]            scan_y;
   logic signed [ZW+1:0]   scan_z;
   logic                   scan_inb;
   logic [SPAN-1:0]        dx_mask;
   logic signed [DZ_W-1:0] r_s;
   logic                   out_free;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_v_ff || rsp_ch.ready;
   assign r_s          = DZ_W'(signed'({1'b0, radius_ff}));

   assign scan_y   = {1'b0, py_ff} + (YW+1)'(dy_ff);
   assign scan_z   = (ZW+2)'(signed'({2'b00, pz_ff})) + (ZW+2)'(dz_ff);
   assign scan_inb = (scan_y < (YW+1)'(GRID_Y)) && (scan_z >= 0)
                     && (scan_z < (ZW+2)'(GRID_Z));

   // dx offsets inside both the square and the disk for the current dz
   always_comb begin
      logic signed [DZ_W:0] dx;
      logic [6:0]           dsq;
      for (int i = 0; i < SPAN; i++) begin
         dx  = (DZ_W+1)'(i - MAX_RADIUS);
         dsq = 7'(dx * dx) + 7'(dz_ff * dz_ff);
         dx_mask[i] = (dx <= (DZ_W+1)'(r_s)) && (dx >= -(DZ_W+1)'(r_s))
                      && (signed'({3'b000, dsq, 8'h00}) <= (LIMIT_W+1)'(limit_ff));
      end
   end

   vcf_lane_count u_lane (
      .row   (ram_rdata),
      .ctl   (p1_ctl_ff),
      .count (lane_cnt)
   );

   vcf_ram #(.WIDTH(GRID_X), .DEPTH(ROWS)) u_grid (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      pz_in       = pz_ff;
      occ_in      = occ_ff;
      walk_in     = walk_ff;
      waddr_in    = waddr_ff;
      dy_in       = dy_ff;
      dz_in       = dz_ff;
      acc_in      = acc_ff;
      rsp_v_in    = rsp_v_ff && !rsp_ch.ready;
      rsp_walk_in = rsp_walk_ff;
      rsp_hits_in = rsp_hits_ff;
      ram_we      = 1'b0;
      ram_waddr   = waddr_ff;
      ram_wdata   = ram_rdata;
      ram_re      = 1'b0;
      ram_raddr   = {scan_y[YW-1:0], scan_z[ZW-1:0]};

      // Accumulate hit counts leaving the pipeline
      if (p2_v_ff) acc_in = acc_ff + HIT_W'(p2_cnt_ff);

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(ROWS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_xfer) begin
               px_in   = req_ch.pos_x;
               py_in   = req_ch.pos_y;
               pz_in   = req_ch.pos_z;
               occ_in  = req_ch.occupied;
               walk_in = req_ch.walkable_in;
               acc_in  = '0;
               dy_in   = climb_ff;
               dz_in   = -r_s;
               if (req_ch.op == OP_WRITE) begin
                  // Read the row now, merge and write it back next cycle
                  ram_re    = 1'b1;
                  ram_raddr = {req_ch.pos_y, req_ch.pos_z};
                  waddr_in  = {req_ch.pos_y, req_ch.pos_z};
                  state_in  = ST_WMOD;
               end else if (req_ch.walkable_in && (climb_ff <= height_ff)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_WMOD: begin
            ram_we               = 1'b1;
            ram_wdata[px_ff]     = occ_ff;
            state_in             = ST_IDLE;
         end
         ST_SCAN: begin
            ram_re = scan_inb;
            if (dz_ff == r_s) begin
               dz_in = -r_s;
               if (dy_ff == height_ff) state_in = ST_DRAIN;
               else dy_in = dy_ff + 1'b1;
            end else begin
               dz_in = dz_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!p1_v_ff && !p2_v_ff) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_v_in    = 1'b1;
               rsp_walk_in = walk_ff && (acc_ff == '0);
               rsp_hits_in = acc_ff;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         p1_v_ff  <= 1'b0;
         p2_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         p1_v_ff  <= (state_ff == ST_SCAN);
         p2_v_ff  <= p1_v_ff;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      occ_ff      <= occ_in;
      walk_ff     <= walk_in;
      waddr_ff    <= waddr_in;
      dy_ff       <= dy_in;
      dz_ff       <= dz_in;
      acc_ff      <= acc_in;
      p1_in_ff    <= scan_inb;
      p1_ctl_ff   <= '{px: px_ff, dx_mask: dx_mask};
      p2_cnt_ff   <= p1_in_ff ? lane_cnt : '0;
      rsp_walk_ff <= rsp_walk_in;
      rsp_hits_ff <= rsp_hits_in;
   end

   assign rsp_ch.valid        = rsp_v_ff;
   assign rsp_ch.walkable_out = rsp_walk_ff;
   assign rsp_ch.hit_count    = rsp_hits_ff;
endmodule

>>> sv/vcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vcf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> sv/vcf_lane_count.sv
// Masked population count of one occupancy row around the query column.
module vcf_lane_count import vcf_pkg::*; (
   input  logic [GRID_X-1:0] row,
   input  lane_ctl_type      ctl,
   output logic [CNT_W-1:0]  count
);
   localparam int WW = GRID_X + SPAN;
   logic [WW-1:0]     win;
   logic [GRID_X-1:0] hits;

   // Bit x+MAX_RADIUS of win selects dx = x - px.
   assign win  = {{GRID_X{1'b0}}, ctl.dx_mask} << ctl.px;
   assign hits = row & win[MAX_RADIUS +: GRID_X];

   always_comb begin
      count = '0;
      for (int i = 0; i < GRID_X; i++) count = count + CNT_W'(hits[i]);
   end
endmodule

>>> sv/vcf_checker.sv
// Checker: port-level properties of the clearance filter, bound to the top.
module vcf_checker import vcf_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_op,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_walkable_out,
   input logic [HIT_W-1:0] rsp_hit_count
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hit_count) && $stable(rsp_walkable_out))
      else $error("response payload changed while stalled");

   a_hits_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_hit_count != '0) |-> !rsp_walkable_out)
      else $error("walkable reported with hits");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while busy");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_WRITE) && !rsp_valid |=> !rsp_valid)
      else $error("response produced by a write");
endmodule

bind voxel_clearance_filter vcf_checker u_vcf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_op           (req_ch.op),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_walkable_out (rsp_ch.walkable_out),
   .rsp_hit_count    (rsp_ch.hit_count)
);
